// File: src/drainage_basin_labeler_defines.svh
// ----------------------------------------------------------------------------
// drainage basin labeler assertion macros
// shared property forms for the labeler's concurrent checks
// ----------------------------------------------------------------------------
`ifndef DRAINAGE_BASIN_LABELER_DEFINES_SVH
`define DRAINAGE_BASIN_LABELER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define DBL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define DBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/dbl_pkg.sv
// ----------------------------------------------------------------------------
// dbl_pkg
// types and constants shared by the drainage basin labeler modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dbl_pkg;

  localparam int OPCODE_W   = 2;
  localparam int IN_ROW_W   = 6;
  localparam int IN_COL_W   = 6;
  localparam int IN_HEIGHT_W = 16;
  localparam int LABEL_W    = 12;
  localparam int STATUS_W   = 2;
  localparam int STORE_W    = 13;   // stored label + 1, zero is unlabeled
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CMP_W      = 9;    // holds any grid size up to 256
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 16;

  localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_UNLAB = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_W = 2'd1,
    DIR_E = 2'd2,
    DIR_S = 2'd3
  } dir_e;

  // controller to datapath
  typedef struct packed {
    logic res_ok;
    logic res_range;
    logic res_rd;
    logic in_wr;
    logic in_rd;
    logic clr_init;
    logic clr_step;
    logic scan_init;
    logic scan_rd;
    logic scan_step;
    logic walk_from_scan;
    logic walk_rd;
    logic walk_to_nb;
    logic lab_wr;
    logic found_from_lab;
    logic found_from_next;
    logic nb_init;
    logic nb_rd;
    logic nb_cmp;
    logic nb_inc;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic in_inb;
    logic clr_last;
    logic grid_empty;
    logic scan_last;
    logic lab_nz;
    logic nb_inb;
    logic dir_last;
    logic has_lower;
  } sts_t;

endpackage

`default_nettype wire

// File: src/drainage_basin_labeler.sv
// ----------------------------------------------------------------------------
// drainage_basin_labeler
// steepest-descent watershed labeler over a stored height map
// ----------------------------------------------------------------------------
// Commands arrive as stream beats: a height write (opcode 0), opcode 3 or any
// out-of-range command returns its result beat in the cycle after acceptance;
// an in-range label read (opcode 2) passes a read-out state first. A labelling
// run (opcode 1) first sweeps the label store clear, one entry a cycle, over
// MAX_ROWS * 2^clog2(MAX_COLS) entries (4096 at the defaults), then scans the
// grid in raster order, reading each cell's label. For each step of a descent
// path it reads the cell's label, then reads and compares every in-bounds
// neighbour's height and skips edge directions (a step that meets a labelled
// cell stops there), each path being walked twice (once to find its label,
// once to write it); a final done state raises the result beat. The height
// and label memories are single-port. After reset the same clearing sweep runs
// before the first beat is taken; config writes are accepted throughout.
`timescale 1ns / 1ps
`default_nettype none

module drainage_basin_labeler #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // config write port
  input  wire logic                            cfg_we_i,
  input  wire logic [dbl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [dbl_pkg::CFG_W-1:0]       cfg_data_i,
  // command beats
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [dbl_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // row, col, height, zero pad
  input  wire logic [dbl_pkg::OPCODE_W-1:0]    s_axis_tuser,  // opcode
  // result beats
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [dbl_pkg::M_TDATA_W-1:0]        m_axis_tdata,  // label, zero pad
  output logic [dbl_pkg::STATUS_W-1:0]         m_axis_tuser   // status
);
  import dbl_pkg::*;

  cmd_t                   cmd;
  sts_t                   sts;
  logic [LABEL_W-1:0]     label;
  logic [IN_ROW_W-1:0]    row;
  logic [IN_COL_W-1:0]    col;
  logic [IN_HEIGHT_W-1:0] height;

  // unpack the command beat
  assign row    = s_axis_tdata[IN_ROW_W-1:0];
  assign col    = s_axis_tdata[IN_ROW_W+IN_COL_W-1:IN_ROW_W];
  assign height = s_axis_tdata[IN_ROW_W+IN_COL_W+IN_HEIGHT_W-1:IN_ROW_W+IN_COL_W];

  // sequencer: owns the state machine and the retrace flag
  dbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // stores, scan and walk pointers, descent compare, result register
  dbl_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .row_i      (row),
    .col_i      (col),
    .height_i   (height),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_label_o  (label),
    .m_status_o (m_axis_tuser)
  );

  // pack the result beat
  assign m_axis_tdata = M_TDATA_W'(label);

endmodule

`default_nettype wire

// File: src/dbl_ram.sv
// ----------------------------------------------------------------------------
// dbl_ram
// single-port ram, one write or read per cycle, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// File: src/dbl_ctrl.sv
// ----------------------------------------------------------------------------
// dbl_ctrl
// sequencer for commands, clearing sweep and descent-path walks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "drainage_basin_labeler_defines.svh"

module dbl_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_tvalid_i,
  input  wire logic [dbl_pkg::OPCODE_W-1:0]    opcode_i,
  output logic                                 s_tready_o,
  input  wire dbl_pkg::sts_t                   sts_i,
  output dbl_pkg::cmd_t                        cmd_o
);
  import dbl_pkg::*;

  typedef enum logic [10:0] {
    S_CLR      = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_RDOUT    = 11'b000_0000_0100,
    S_SCAN_RD  = 11'b000_0000_1000,
    S_SCAN_CHK = 11'b000_0001_0000,
    S_WALK_RD  = 11'b000_0010_0000,
    S_WALK_CHK = 11'b000_0100_0000,
    S_NB_RD    = 11'b000_1000_0000,
    S_NB_CMP   = 11'b001_0000_0000,
    S_DESC     = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   run_q, run_d;
  logic   retrace_q, retrace_d;
  logic   accept;

  assign s_tready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    run_d     = run_q;
    retrace_d = retrace_q;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          if (!run_q) begin
            state_d = S_IDLE;
          end else if (sts_i.grid_empty) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN_RD;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_WRITE: begin
              if (sts_i.in_inb) begin
                cmd_o.in_wr  = 1'b1;
                cmd_o.res_ok = 1'b1;
              end else begin
                cmd_o.res_range = 1'b1;
              end
            end
            OP_READ: begin
              if (sts_i.in_inb) begin
                cmd_o.in_rd = 1'b1;
                state_d     = S_RDOUT;
              end else begin
                cmd_o.res_range = 1'b1;
              end
            end
            OP_RUN: begin
              cmd_o.clr_init  = 1'b1;
              cmd_o.scan_init = 1'b1;
              run_d           = 1'b1;
              state_d         = S_CLR;
            end
            default: begin
              cmd_o.res_ok = 1'b1;
            end
          endcase
        end
      end
      S_RDOUT: begin
        cmd_o.res_rd = 1'b1;
        state_d      = S_IDLE;
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts_i.lab_nz) begin
          if (sts_i.scan_last) begin
            state_d = S_DONE;
          end else begin
            cmd_o.scan_step = 1'b1;
            state_d         = S_SCAN_RD;
          end
        end else begin
          cmd_o.walk_from_scan = 1'b1;
          retrace_d            = 1'b0;
          state_d              = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        cmd_o.walk_rd = 1'b1;
        state_d       = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (sts_i.lab_nz) begin
          if (!retrace_q) begin
            // path ran into a labelled cell: take its label, go back to the start
            cmd_o.found_from_lab = 1'b1;
            cmd_o.walk_from_scan = 1'b1;
            retrace_d            = 1'b1;
            state_d              = S_WALK_RD;
          end else if (sts_i.scan_last) begin
            state_d = S_DONE;
          end else begin
            cmd_o.scan_step = 1'b1;
            state_d         = S_SCAN_RD;
          end
        end else begin
          cmd_o.lab_wr  = retrace_q;
          cmd_o.nb_init = 1'b1;
          state_d       = S_NB_RD;
        end
      end
      S_NB_RD: begin
        if (sts_i.nb_inb) begin
          cmd_o.nb_rd = 1'b1;
          state_d     = S_NB_CMP;
        end else if (sts_i.dir_last) begin
          state_d = S_DESC;
        end else begin
          cmd_o.nb_inc = 1'b1;
        end
      end
      S_NB_CMP: begin
        cmd_o.nb_cmp = 1'b1;
        if (sts_i.dir_last) begin
          state_d = S_DESC;
        end else begin
          cmd_o.nb_inc = 1'b1;
          state_d      = S_NB_RD;
        end
      end
      S_DESC: begin
        if (sts_i.has_lower) begin
          cmd_o.walk_to_nb = 1'b1;
          state_d          = S_WALK_RD;
        end else if (!retrace_q) begin
          // new sink: next free label
          cmd_o.found_from_next = 1'b1;
          cmd_o.walk_from_scan  = 1'b1;
          retrace_d             = 1'b1;
          state_d               = S_WALK_RD;
        end else if (sts_i.scan_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d         = S_SCAN_RD;
        end
      end
      S_DONE: begin
        cmd_o.res_ok = 1'b1;
        run_d        = 1'b0;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      run_q     <= 1'b0;
      retrace_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      run_q     <= run_d;
      retrace_q <= retrace_d;
    end
  end

  `DBL_ASSERT_NOW(a_lab_wr_retrace, cmd_o.lab_wr, retrace_q, "label write outside retrace")
  `DBL_ASSERT_NEXT(a_run_clears, accept && (opcode_i == OP_RUN), state_q == S_CLR,
                   "run did not start with a clearing sweep")
  `DBL_ASSERT_NEXT(a_read_result, cmd_o.in_rd, cmd_o.res_rd, "label read not followed by result")

endmodule

`default_nettype wire

// File: src/dbl_dp.sv
// ----------------------------------------------------------------------------
// dbl_dp
// datapath: grid registers, height and label stores, descent unit, result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "drainage_basin_labeler_defines.svh"

module dbl_dp #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire dbl_pkg::cmd_t                    cmd_i,
  output dbl_pkg::sts_t                         sts_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [dbl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [dbl_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire logic [dbl_pkg::IN_ROW_W-1:0]     row_i,
  input  wire logic [dbl_pkg::IN_COL_W-1:0]     col_i,
  input  wire logic [dbl_pkg::IN_HEIGHT_W-1:0]  height_i,
  input  wire logic                             m_tready_i,
  output logic                                  m_tvalid_o,
  output logic [dbl_pkg::LABEL_W-1:0]           m_label_o,
  output logic [dbl_pkg::STATUS_W-1:0]          m_status_o
);
  import dbl_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_ROWS << CW;
  localparam logic [CMP_W-1:0] MAXR = CMP_W'(MAX_ROWS);
  localparam logic [CMP_W-1:0] MAXC = CMP_W'(MAX_COLS);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);

  logic [CFG_W-1:0]       rows_q, cols_q;
  logic [CMP_W-1:0]       eff_r, eff_c;
  logic [CMP_W-1:0]       in_r_ext, in_c_ext;
  logic [AW-1:0]          in_addr;
  logic [AW-1:0]          clr_q;
  logic [RW-1:0]          scan_r_q, walk_r_q;
  logic [CW-1:0]          scan_c_q, walk_c_q;
  logic [1:0]             dir_q, best_dir_q;
  logic [HEIGHT_BITS-1:0] best_h_q;
  logic                   has_q;
  logic [STORE_W-1:0]     found_q, next_q;
  logic                   out_valid_q;
  logic [LABEL_W-1:0]     out_label_q;
  logic [STATUS_W-1:0]    out_status_q;
  logic [RW-1:0]          nb_r, bn_r;
  logic [CW-1:0]          nb_c, bn_c;
  logic                   scan_c_end;

  logic                   h_we, l_we;
  logic [AW-1:0]          h_addr, l_addr;
  logic [HEIGHT_BITS-1:0] h_rdata;
  logic [STORE_W-1:0]     l_wdata, l_rdata;

  // neighbour of the walk cell in a given direction
  function automatic logic [RW+CW-1:0] nb_of(input logic [1:0] d, input logic [RW-1:0] r,
                                             input logic [CW-1:0] c);
    logic [RW-1:0] rr;
    logic [CW-1:0] cc;
    rr = r;
    cc = c;
    case (d)
      DIR_N:   rr = r - 1'b1;
      DIR_W:   cc = c - 1'b1;
      DIR_E:   cc = c + 1'b1;
      DIR_S:   rr = r + 1'b1;
      default: rr = r;
    endcase
    return {rr, cc};
  endfunction

  assign eff_r = ({2'b00, rows_q} > MAXR) ? MAXR : CMP_W'(rows_q);
  assign eff_c = ({2'b00, cols_q} > MAXC) ? MAXC : CMP_W'(cols_q);

  assign in_r_ext = CMP_W'(row_i);
  assign in_c_ext = CMP_W'(col_i);
  assign in_addr  = {in_r_ext[RW-1:0], in_c_ext[CW-1:0]};

  assign {nb_r, nb_c} = nb_of(dir_q, walk_r_q, walk_c_q);
  assign {bn_r, bn_c} = nb_of(best_dir_q, walk_r_q, walk_c_q);

  assign scan_c_end = (CMP_W'(scan_c_q) + CMP_W'(1)) == eff_c;

  // status
  always_comb begin
    sts_o            = '0;
    sts_o.out_free   = !out_valid_q || m_tready_i;
    sts_o.in_inb     = (in_r_ext < eff_r) && (in_c_ext < eff_c);
    sts_o.clr_last   = clr_q == LAST_ADDR;
    sts_o.grid_empty = (eff_r == '0) || (eff_c == '0);
    sts_o.scan_last  = scan_c_end && ((CMP_W'(scan_r_q) + CMP_W'(1)) == eff_r);
    sts_o.lab_nz     = l_rdata != '0;
    sts_o.dir_last   = dir_q == DIR_S;
    sts_o.has_lower  = has_q;
    case (dir_q)
      DIR_N:   sts_o.nb_inb = walk_r_q != '0;
      DIR_W:   sts_o.nb_inb = walk_c_q != '0;
      DIR_E:   sts_o.nb_inb = (CMP_W'(walk_c_q) + CMP_W'(1)) < eff_c;
      DIR_S:   sts_o.nb_inb = (CMP_W'(walk_r_q) + CMP_W'(1)) < eff_r;
      default: sts_o.nb_inb = 1'b0;
    endcase
  end

  // store ports
  always_comb begin
    h_we    = cmd_i.in_wr;
    h_addr  = {walk_r_q, walk_c_q};
    if (cmd_i.in_wr) begin
      h_addr = in_addr;
    end else if (cmd_i.nb_rd) begin
      h_addr = {nb_r, nb_c};
    end
    l_we    = cmd_i.clr_step || cmd_i.lab_wr;
    l_wdata = cmd_i.lab_wr ? STORE_W'(found_q + 1'b1) : '0;
    l_addr  = {walk_r_q, walk_c_q};
    if (cmd_i.clr_step) begin
      l_addr = clr_q;
    end else if (cmd_i.in_rd) begin
      l_addr = in_addr;
    end else if (cmd_i.scan_rd) begin
      l_addr = {scan_r_q, scan_c_q};
    end
  end

  dbl_ram #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .addr_i  (h_addr),
    .wdata_i (HEIGHT_BITS'(height_i)),
    .rdata_o (h_rdata)
  );

  dbl_ram #(
    .WIDTH (STORE_W),
    .DEPTH (DEPTH)
  ) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .addr_i  (l_addr),
    .wdata_i (l_wdata),
    .rdata_o (l_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= ROWS_RESET;
      cols_q      <= COLS_RESET;
      clr_q       <= '0;
      next_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ROWS) begin
          rows_q <= cfg_data_i;
        end else if (cfg_idx_i == CFG_COLS) begin
          cols_q <= cfg_data_i;
        end
      end
      if (cmd_i.clr_init) begin
        clr_q  <= '0;
        next_q <= '0;
      end else begin
        if (cmd_i.clr_step) begin
          clr_q <= sts_o.clr_last ? '0 : clr_q + 1'b1;
        end
        if (cmd_i.found_from_next) begin
          next_q <= next_q + 1'b1;
        end
      end
      if (cmd_i.res_ok || cmd_i.res_range || cmd_i.res_rd) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      scan_r_q <= '0;
      scan_c_q <= '0;
    end else if (cmd_i.scan_step) begin
      if (scan_c_end) begin
        scan_c_q <= '0;
        scan_r_q <= scan_r_q + 1'b1;
      end else begin
        scan_c_q <= scan_c_q + 1'b1;
      end
    end
    if (cmd_i.walk_from_scan) begin
      walk_r_q <= scan_r_q;
      walk_c_q <= scan_c_q;
    end else if (cmd_i.walk_to_nb) begin
      walk_r_q <= bn_r;
      walk_c_q <= bn_c;
    end
    if (cmd_i.found_from_lab) begin
      found_q <= l_rdata - 1'b1;
    end else if (cmd_i.found_from_next) begin
      found_q <= next_q;
    end
    if (cmd_i.nb_init) begin
      best_h_q <= h_rdata;
      has_q    <= 1'b0;
      dir_q    <= DIR_N;
    end else begin
      if (cmd_i.nb_cmp && (h_rdata < best_h_q)) begin
        best_h_q   <= h_rdata;
        best_dir_q <= dir_q;
        has_q      <= 1'b1;
      end
      if (cmd_i.nb_inc) begin
        dir_q <= dir_q + 1'b1;
      end
    end
    if (cmd_i.res_ok) begin
      out_label_q  <= '0;
      out_status_q <= ST_OK;
    end else if (cmd_i.res_range) begin
      out_label_q  <= '0;
      out_status_q <= ST_RANGE;
    end else if (cmd_i.res_rd) begin
      if (l_rdata == '0) begin
        out_label_q  <= '0;
        out_status_q <= ST_UNLAB;
      end else begin
        out_label_q  <= LABEL_W'(l_rdata - 1'b1);
        out_status_q <= ST_OK;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_label_o  = out_label_q;
  assign m_status_o = out_status_q;

  `DBL_ASSERT_NOW(a_nb_rd_inb, cmd_i.nb_rd, sts_o.nb_inb, "neighbour read outside the grid")
  `DBL_ASSERT_NEXT(a_clr_wrap, cmd_i.clr_step && sts_o.clr_last, clr_q == '0,
                   "clear counter did not wrap after last entry")

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// drainage basin labeler testbench
// drives height writes, labelling runs and label reads over several grid
// sizes, predicts every result beat and checks it against the block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import dbl_pkg::*;

  localparam int GRID_SIDE  = 64;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int CYCLE_CAP  = 4000000;

  typedef struct {
    op_e         op;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] height;
  } cmd_beat_t;

  typedef struct {
    logic [LABEL_W-1:0] label;
    status_e            status;
  } result_beat_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [OPCODE_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;

  drainage_basin_labeler u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // row, col, height, zero pad
    .s_axis_tuser (s_axis_tuser),   // opcode
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // label, zero pad
    .m_axis_tuser (m_axis_tuser)    // status
  );

  // shadow copy of the block's state
  logic [15:0] height_mem [GRID_CELLS];
  logic [12:0] basin_mem  [GRID_CELLS];
  logic [12:0] basin_next;
  logic [6:0]  grid_rows;
  logic [6:0]  grid_cols;

  // generation side bookkeeping: which heights have been written
  bit          height_known [GRID_CELLS];

  cmd_beat_t    cmd_q [$];
  result_beat_t result_q [$];
  bit           failed;
  bit           quiet;
  int           beats_checked;
  int           runs_seen;
  int           cycle_count;

  // ---------------------------------------------------------------- predictor

  function automatic int rows_used();
    return (grid_rows > GRID_SIDE) ? GRID_SIDE : int'(grid_rows);
  endfunction

  function automatic int cols_used();
    return (grid_cols > GRID_SIDE) ? GRID_SIDE : int'(grid_cols);
  endfunction

  // steepest strictly lower neighbour, scanned north, west, east, south; -1 for a sink
  function automatic int steepest_neighbour(int loc, int nr, int nc);
    int dr [4];
    int dc [4];
    int r;
    int c;
    int rr;
    int cc;
    int best_cell;
    logic [15:0] best_h;
    dr = '{-1, 0, 0, 1};
    dc = '{0, -1, 1, 0};
    r = loc / GRID_SIDE;
    c = loc % GRID_SIDE;
    best_h = height_mem[loc];
    best_cell = -1;
    for (int d = 0; d < 4; d++) begin
      rr = r + dr[d];
      cc = c + dc[d];
      if (rr >= 0 && cc >= 0 && rr < nr && cc < nc) begin
        if (height_mem[rr * GRID_SIDE + cc] < best_h) begin
          best_h = height_mem[rr * GRID_SIDE + cc];
          best_cell = rr * GRID_SIDE + cc;
        end
      end
    end
    return best_cell;
  endfunction

  function automatic void label_basins();
    int nr;
    int nc;
    int start;
    int walk;
    int nxt;
    logic [12:0] found;
    nr = rows_used();
    nc = cols_used();
    foreach (basin_mem[i]) basin_mem[i] = '0;
    basin_next = '0;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        start = r * GRID_SIDE + c;
        if (basin_mem[start] == 0) begin
          // follow the descent to learn the basin
          walk = start;
          forever begin
            if (basin_mem[walk] != 0) begin
              found = basin_mem[walk] - 13'd1;
              break;
            end
            nxt = steepest_neighbour(walk, nr, nc);
            if (nxt < 0) begin
              found = basin_next;
              basin_next = basin_next + 13'd1;
              break;
            end
            walk = nxt;
          end
          // retrace and paint
          walk = start;
          while (basin_mem[walk] == 0) begin
            basin_mem[walk] = found + 13'd1;
            nxt = steepest_neighbour(walk, nr, nc);
            if (nxt < 0) break;
            walk = nxt;
          end
        end
      end
    end
  endfunction

  function automatic result_beat_t predict_result(cmd_beat_t cmd);
    result_beat_t res;
    int idx;
    res.label = '0;
    res.status = ST_OK;
    if (cmd.op == OP_WRITE || cmd.op == OP_READ) begin
      if (cmd.row >= rows_used() || cmd.col >= cols_used()) begin
        res.status = ST_RANGE;
      end else begin
        idx = cmd.row * GRID_SIDE + cmd.col;
        if (cmd.op == OP_WRITE) begin
          height_mem[idx] = cmd.height;
        end else if (basin_mem[idx] == 0) begin
          res.status = ST_UNLAB;
        end else begin
          res.label = LABEL_W'(basin_mem[idx] - 13'd1);
        end
      end
    end else if (cmd.op == OP_RUN) begin
      label_basins();
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- clock and limit

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("[drainage_basin_labeler] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driver

  cmd_beat_t held_cmd;
  int        send_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      send_gap      <= 0;
    end else begin
      // a command beat taken at this edge is predicted against the shadow state
      if (s_axis_tvalid && s_axis_tready) begin
        result_q.push_back(predict_result(held_cmd));
        if (held_cmd.op == OP_RUN) runs_seen++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          held_cmd = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= held_cmd.op;
          s_axis_tdata  <= {4'd0, held_cmd.height, held_cmd.col, held_cmd.row};
          if (!quiet && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 5);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  int           stall_left;
  result_beat_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected: label %0d status %0d",
                 m_axis_tdata[LABEL_W-1:0], m_axis_tuser);
          failed = 1'b1;
        end else begin
          want = result_q.pop_front();
          beats_checked++;
          if (m_axis_tdata !== M_TDATA_W'(want.label)) begin
            $error("label: expected %0d, got %0d", want.label, m_axis_tdata);
            failed = 1'b1;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            failed = 1'b1;
          end
        end
      end
      // back-pressure bursts
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_cmd(op_e op, int row, int col, logic [15:0] height);
    cmd_beat_t cmd;
    cmd.op = op;
    cmd.row = 6'(row);
    cmd.col = 6'(col);
    cmd.height = height;
    if (op == OP_WRITE && row < rows_used() && col < cols_used())
      height_known[row * GRID_SIDE + col] = 1'b1;
    cmd_q.push_back(cmd);
  endtask

  // wait until every queued command has gone and every result has arrived;
  // sampled mid-cycle so the driver's updates at the edge are settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_q.size() > 0 || s_axis_tvalid || result_q.size() > 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == CFG_ROWS) grid_rows = value;
    else grid_cols = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // every height a run may read must be known beforehand
  task automatic fill_grid();
    for (int r = 0; r < rows_used(); r++)
      for (int c = 0; c < cols_used(); c++)
        if (!height_known[r * GRID_SIDE + c])
          push_cmd(OP_WRITE, r, c, 16'($urandom_range(0, 7)));
  endtask

  function automatic logic [15:0] pick_height();
    case ($urandom_range(0, 3))
      0: return 16'hFFFF;
      1: return 16'($urandom());
      default: return 16'($urandom_range(0, 9));   // low spread gives ties
    endcase
  endfunction

  task automatic random_cmd();
    int row;
    int col;
    int kind;
    kind = $urandom_range(0, 15);
    if (rows_used() > 0 && cols_used() > 0 && kind < 14) begin
      row = $urandom_range(0, rows_used() - 1);
      col = $urandom_range(0, cols_used() - 1);
    end else begin
      row = $urandom_range(0, 63);
      col = $urandom_range(0, 63);
    end
    if (kind < 6 || kind == 15) push_cmd(OP_WRITE, row, col, pick_height());
    else if (kind < 13) push_cmd(OP_READ, row, col, 16'($urandom()));
    else if (kind == 13) push_cmd(OP_RUN, row, col, 16'($urandom()));
    else push_cmd(OP_NOP, row, col, 16'($urandom()));
  endtask

  task automatic run_phase(int rows_val, int cols_val, int count, bit last_phase);
    wait_drained();
    write_reg(CFG_ROWS, CFG_W'(rows_val));
    write_reg(CFG_COLS, CFG_W'(cols_val));
    quiet = last_phase;
    fill_grid();
    for (int n = 0; n < count; n++) random_cmd();
    push_cmd(OP_RUN, 0, 0, '0);
    for (int n = 0; n < 8; n++) random_cmd();
  endtask

  initial begin
    int phase_rows [8];
    int phase_cols [8];
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    rst_ni     = 1'b0;
    failed     = 1'b0;
    quiet      = 1'b0;
    cycle_count = 0;
    beats_checked = 0;
    runs_seen = 0;
    foreach (height_mem[i]) height_mem[i] = '0;
    foreach (basin_mem[i]) basin_mem[i] = '0;
    foreach (height_known[i]) height_known[i] = 1'b0;
    basin_next = '0;
    grid_rows  = ROWS_RESET;
    grid_cols  = COLS_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: small grid with a known shape, three corners at the height extremes
    write_reg(CFG_ROWS, 7'd4);
    write_reg(CFG_COLS, 7'd5);
    push_cmd(OP_READ, 0, 0, '0);            // nothing labelled yet
    push_cmd(OP_WRITE, 0, 0, 16'hFFFF);
    push_cmd(OP_WRITE, 3, 4, 16'h0000);
    push_cmd(OP_WRITE, 0, 4, 16'h0000);
    push_cmd(OP_WRITE, 63, 63, 16'h1234);   // outside the grid, ignored
    push_cmd(OP_WRITE, 4, 0, 16'h1234);
    fill_grid();
    push_cmd(OP_NOP, 63, 63, 16'hFFFF);
    push_cmd(OP_RUN, 0, 0, '0);
    push_cmd(OP_READ, 0, 0, '0);
    push_cmd(OP_READ, 3, 4, '0);
    push_cmd(OP_READ, 0, 4, '0);
    push_cmd(OP_READ, 2, 2, '0);
    push_cmd(OP_READ, 0, 5, '0);            // one column too far
    push_cmd(OP_READ, 63, 0, '0);
    // heights change but labels stay until the next run
    push_cmd(OP_WRITE, 1, 1, 16'hFFFF);
    push_cmd(OP_READ, 1, 1, '0);
    push_cmd(OP_RUN, 0, 0, '0);
    push_cmd(OP_READ, 1, 1, '0);

    // random phases over several grid shapes, extremes and saturation included
    phase_rows = '{1, 64, 1, 0, 100, 3, 2, 5};
    phase_cols = '{1, 2, 64, 3, 2, 0, 127, 6};
    for (int p = 0; p < 8; p++) run_phase(phase_rows[p], phase_cols[p], 28, 1'b0);
    // larger grid after a shape change: stale labels outside the old grid
    run_phase(9, 11, 28, 1'b0);
    run_phase(6, 8, 28, 1'b1);
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("covered %0d result beats over %0d labelling runs on ten grid shapes",
             beats_checked, runs_seen);
    if (!failed && result_q.size() == 0) begin
      $display("[drainage_basin_labeler] OK");
    end else begin
      $display("[drainage_basin_labeler] ERROR");
    end
    $finish;
  end

endmodule
